// ===== sv/km_pkg.sv =====
// ----------------------------------------------------------------------------
// km_pkg
// Shared widths, command codes and control types for the k-means engine.
// ----------------------------------------------------------------------------
package km_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIM      = 8;
    localparam int COORD_W      = 32;

    localparam int PI_W   = $clog2(MAX_POINTS);
    localparam int NP_W   = PI_W + 1;
    localparam int CI_W   = $clog2(MAX_CLUSTERS);
    localparam int NC_W   = CI_W + 1;
    localparam int DI_W   = $clog2(MAX_DIM);
    localparam int ND_W   = DI_W + 1;
    localparam int SUM_W  = COORD_W + PI_W;
    localparam int DIST_W = 64;
    localparam int CFG_W  = NP_W;

    localparam logic [2:0] KIND_LOAD_PNT = 3'd0;
    localparam logic [2:0] KIND_LOAD_CEN = 3'd1;
    localparam logic [2:0] KIND_INIT     = 3'd2;
    localparam logic [2:0] KIND_PASS     = 3'd3;
    localparam logic [2:0] KIND_READ     = 3'd4;

    localparam logic [1:0] REG_NUM_POINTS   = 2'd0;
    localparam logic [1:0] REG_NUM_CLUSTERS = 2'd1;
    localparam logic [1:0] REG_DIMS_IN_USE  = 2'd2;

    typedef struct packed {
        logic mul;
        logic acc;
        logic first;
    } t_sqd_ctl;

endpackage

// ===== sv/kmeans_lloyd_iteration.sv =====
// ----------------------------------------------------------------------------
// kmeans_lloyd_iteration
// One-pass Lloyd k-means engine over signed Q15.16 coordinates.
//
// Requests arrive on i_valid/o_ready; each gives exactly one result on
// o_valid/i_ready. The block takes one request at a time and is not ready
// until the result has been taken. Loads answer straight from the idle
// state; a centroid read first waits in S_RDW for the memory read. An init
// command sets each centroid to the mean of its own block of np/nc points; a
// pass assigns every point, reseeds each empty cluster from a stored point,
// and, without empty clusters, recomputes the means. All distances come from
// the single squared-difference unit walking every point-centroid pair one
// coordinate at a time, and all divisions from the bit-serial divider (one
// bit of 42 per cycle). A stalled result is held on the output registers
// until i_ready. Reset sets the configuration registers to one and clears the
// reseed pointer and the cluster counts; point and centroid memories hold
// garbage until written.
// Configuration writes are taken at any cycle on i_cfg_we.
// ----------------------------------------------------------------------------
module kmeans_lloyd_iteration (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [km_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_kind,
    input  logic [km_pkg::PI_W-1:0]           i_point_index,
    input  logic [km_pkg::CI_W-1:0]           i_cluster_index,
    input  logic [km_pkg::DI_W-1:0]           i_dim_index,
    input  logic signed [km_pkg::COORD_W-1:0] i_coord_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [km_pkg::COORD_W-1:0] o_read_value,
    output logic                              o_updated,
    output logic                              o_status
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RDW  = 5'd1;
    localparam logic [4:0] S_RESP = 5'd2;
    localparam logic [4:0] S_ID0  = 5'd3;
    localparam logic [4:0] S_ID1  = 5'd4;
    localparam logic [4:0] S_AR   = 5'd5;
    localparam logic [4:0] S_AM   = 5'd6;
    localparam logic [4:0] S_AA   = 5'd7;
    localparam logic [4:0] S_AC   = 5'd8;
    localparam logic [4:0] S_RC   = 5'd9;
    localparam logic [4:0] S_RR   = 5'd10;
    localparam logic [4:0] S_RW   = 5'd11;
    localparam logic [4:0] S_RN   = 5'd12;
    localparam logic [4:0] S_SS   = 5'd13;
    localparam logic [4:0] S_SR   = 5'd14;
    localparam logic [4:0] S_SA   = 5'd15;
    localparam logic [4:0] S_DV   = 5'd16;
    localparam logic [4:0] S_DW   = 5'd17;
    localparam logic [4:0] S_NX   = 5'd18;

    localparam int PA_W = km_pkg::PI_W + km_pkg::DI_W;
    localparam int CA_W = km_pkg::CI_W + km_pkg::DI_W;

    logic [4:0]                      r_st;
    logic [km_pkg::NP_W-1:0]         r_cfg_np;
    logic [km_pkg::NC_W-1:0]         r_cfg_nc;
    logic [km_pkg::ND_W-1:0]         r_cfg_nd;
    logic [km_pkg::NP_W-1:0]         np;
    logic [km_pkg::NC_W-1:0]         nc;
    logic [km_pkg::ND_W-1:0]         nd;

    logic [km_pkg::NP_W-1:0]         r_i;
    logic [km_pkg::NP_W-1:0]         r_lim;
    logic [km_pkg::NP_W-1:0]         r_base;
    logic [km_pkg::NP_W-1:0]         r_size;
    logic [km_pkg::NP_W-1:0]         r_rp;
    logic [km_pkg::NP_W-1:0]         r_pp;
    logic [km_pkg::CI_W-1:0]         r_c;
    logic [km_pkg::DI_W-1:0]         r_d;
    logic [km_pkg::CI_W-1:0]         r_bidx;
    logic [km_pkg::DIST_W-1:0]       r_best;
    logic                            r_empty;
    logic                            r_init;
    logic signed [km_pkg::SUM_W-1:0] r_sum;
    logic [km_pkg::NP_W-1:0]         r_cnt [km_pkg::MAX_CLUSTERS];

    logic                            r_ovalid;
    logic signed [km_pkg::COORD_W-1:0] r_orv;
    logic                            r_oupd;
    logic                            r_ost;

    logic [km_pkg::COORD_W-1:0]      mem_pnt [km_pkg::MAX_POINTS * km_pkg::MAX_DIM];
    logic [km_pkg::COORD_W-1:0]      mem_cen [km_pkg::MAX_CLUSTERS * km_pkg::MAX_DIM];
    logic [km_pkg::CI_W-1:0]         mem_asg [km_pkg::MAX_POINTS];
    logic signed [km_pkg::COORD_W-1:0] r_prd;
    logic signed [km_pkg::COORD_W-1:0] r_crd;
    logic [km_pkg::CI_W-1:0]         r_ard;

    logic                            acc_in;
    logic                            pt_ok;
    logic                            cl_ok;
    logic                            last_c;
    logic                            last_d;
    logic                            better;
    logic [km_pkg::CI_W-1:0]         nb;
    logic [km_pkg::CI_W-1:0]         cnt_idx;
    logic [km_pkg::NP_W-1:0]         cnt_rd;

    logic                            p_we;
    logic [PA_W-1:0]                 p_waddr;
    logic [PA_W-1:0]                 p_raddr;
    logic                            c_we;
    logic [CA_W-1:0]                 c_waddr;
    logic [km_pkg::COORD_W-1:0]      c_wdata;
    logic [CA_W-1:0]                 c_raddr;
    logic                            a_we;

    km_pkg::t_sqd_ctl                sqd_ctl;
    logic [km_pkg::DIST_W-1:0]       dist_sum;
    logic                            div_start;
    logic signed [km_pkg::SUM_W-1:0] div_num;
    logic [km_pkg::NP_W-1:0]         div_den;
    logic                            div_done;
    logic signed [km_pkg::SUM_W-1:0] div_q;

    assign np = (r_cfg_np == '0) ? km_pkg::NP_W'(1) :
                (r_cfg_np > km_pkg::NP_W'(km_pkg::MAX_POINTS)) ?
                km_pkg::NP_W'(km_pkg::MAX_POINTS) : r_cfg_np;
    assign nc = (r_cfg_nc == '0) ? km_pkg::NC_W'(1) :
                (r_cfg_nc > km_pkg::NC_W'(km_pkg::MAX_CLUSTERS)) ?
                km_pkg::NC_W'(km_pkg::MAX_CLUSTERS) : r_cfg_nc;
    assign nd = (r_cfg_nd == '0) ? km_pkg::ND_W'(1) :
                (r_cfg_nd > km_pkg::ND_W'(km_pkg::MAX_DIM)) ?
                km_pkg::ND_W'(km_pkg::MAX_DIM) : r_cfg_nd;

    assign o_ready = (r_st == S_IDLE);
    assign acc_in  = i_valid && o_ready;
    assign pt_ok   = ({1'b0, i_point_index} < np) && ({1'b0, i_dim_index} < nd);
    assign cl_ok   = ({1'b0, i_cluster_index} < nc) && ({1'b0, i_dim_index} < nd);
    assign last_c  = ({1'b0, r_c} == nc - 1'b1);
    assign last_d  = ({1'b0, r_d} == nd - 1'b1);
    assign better  = (r_c == '0) || (dist_sum < r_best);
    assign nb      = better ? r_c : r_bidx;
    assign cnt_idx = (r_st == S_AC) ? nb : r_c;
    assign cnt_rd  = r_cnt[cnt_idx];

    assign p_we    = acc_in && (i_kind == km_pkg::KIND_LOAD_PNT) && pt_ok;
    assign p_waddr = {i_point_index, i_dim_index};
    assign p_raddr = (r_st == S_RR) ? {r_pp[km_pkg::PI_W-1:0], r_d}
                                    : {r_i[km_pkg::PI_W-1:0], r_d};
    assign c_raddr = (r_st == S_IDLE) ? {i_cluster_index, i_dim_index} : {r_c, r_d};
    assign a_we    = (r_st == S_AC) && last_c;

    always_comb begin
        c_we    = 1'b0;
        c_waddr = {r_c, r_d};
        c_wdata = '0;
        case (r_st)
            S_IDLE: begin
                c_we    = acc_in && (i_kind == km_pkg::KIND_LOAD_CEN) && cl_ok;
                c_waddr = {i_cluster_index, i_dim_index};
                c_wdata = i_coord_value;
            end
            S_RW: begin
                c_we    = 1'b1;
                c_wdata = r_prd;
            end
            S_DV: begin
                c_we = r_init && (r_size == '0);
            end
            S_DW: begin
                c_we    = div_done;
                c_wdata = div_q[km_pkg::COORD_W-1:0];
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            mem_pnt[p_waddr] <= i_coord_value;
        end
        r_prd <= mem_pnt[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            mem_cen[c_waddr] <= c_wdata;
        end
        r_crd <= mem_cen[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            mem_asg[r_i[km_pkg::PI_W-1:0]] <= nb;
        end
        r_ard <= mem_asg[r_i[km_pkg::PI_W-1:0]];
    end

    assign sqd_ctl.mul   = (r_st == S_AM);
    assign sqd_ctl.acc   = (r_st == S_AA);
    assign sqd_ctl.first = (r_d == '0);

    km_sqd u_sqd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sqd_ctl),
        .i_a     (r_prd),
        .i_b     (r_crd),
        .o_acc   (dist_sum)
    );

    assign div_start = (r_st == S_ID0) || ((r_st == S_DV) && !(r_init && r_size == '0));
    assign div_num   = (r_st == S_ID0) ? km_pkg::SUM_W'(np) : r_sum;
    assign div_den   = (r_st == S_ID0) ? km_pkg::NP_W'(nc) : (r_init ? r_size : cnt_rd);

    km_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_np <= km_pkg::NP_W'(1);
            r_cfg_nc <= km_pkg::NC_W'(1);
            r_cfg_nd <= km_pkg::ND_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                km_pkg::REG_NUM_POINTS:   r_cfg_np <= i_cfg_data;
                km_pkg::REG_NUM_CLUSTERS: r_cfg_nc <= i_cfg_data[km_pkg::NC_W-1:0];
                km_pkg::REG_DIMS_IN_USE:  r_cfg_nd <= i_cfg_data[km_pkg::ND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
            r_rp     <= '0;
            for (int k = 0; k < km_pkg::MAX_CLUSTERS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (acc_in) begin
                        r_orv  <= '0;
                        r_oupd <= 1'b0;
                        r_ost  <= 1'b0;
                        case (i_kind)
                            km_pkg::KIND_LOAD_PNT: begin
                                r_ost    <= !pt_ok;
                                r_ovalid <= 1'b1;
                                r_st     <= S_RESP;
                            end
                            km_pkg::KIND_LOAD_CEN: begin
                                r_ost    <= !cl_ok;
                                r_ovalid <= 1'b1;
                                r_st     <= S_RESP;
                            end
                            km_pkg::KIND_INIT: begin
                                r_st <= S_ID0;
                            end
                            km_pkg::KIND_PASS: begin
                                for (int k = 0; k < km_pkg::MAX_CLUSTERS; k++) begin
                                    r_cnt[k] <= '0;
                                end
                                r_i     <= '0;
                                r_c     <= '0;
                                r_d     <= '0;
                                r_empty <= 1'b0;
                                r_st    <= S_AR;
                            end
                            km_pkg::KIND_READ: begin
                                if (cl_ok) begin
                                    r_st <= S_RDW;
                                end else begin
                                    r_ost    <= 1'b1;
                                    r_ovalid <= 1'b1;
                                    r_st     <= S_RESP;
                                end
                            end
                            default: begin
                                r_ost    <= 1'b1;
                                r_ovalid <= 1'b1;
                                r_st     <= S_RESP;
                            end
                        endcase
                    end
                end
                S_RDW: begin
                    r_orv    <= r_crd;
                    r_ovalid <= 1'b1;
                    r_st     <= S_RESP;
                end
                S_RESP: begin
                    if (i_ready) begin
                        r_ovalid <= 1'b0;
                        r_st     <= S_IDLE;
                    end
                end
                S_ID0: begin
                    r_st <= S_ID1;
                end
                S_ID1: begin
                    if (div_done) begin
                        r_size <= div_q[km_pkg::NP_W-1:0];
                        r_base <= '0;
                        r_c    <= '0;
                        r_d    <= '0;
                        r_init <= 1'b1;
                        r_st   <= S_SS;
                    end
                end
                S_AR: begin
                    r_st <= S_AM;
                end
                S_AM: begin
                    r_st <= S_AA;
                end
                S_AA: begin
                    if (last_d) begin
                        r_st <= S_AC;
                    end else begin
                        r_d  <= r_d + 1'b1;
                        r_st <= S_AR;
                    end
                end
                S_AC: begin
                    r_d <= '0;
                    if (better) begin
                        r_best <= dist_sum;
                        r_bidx <= r_c;
                    end
                    if (last_c) begin
                        r_cnt[cnt_idx] <= cnt_rd + 1'b1;
                        r_c            <= '0;
                        if (r_i + 1'b1 == np) begin
                            r_st <= S_RC;
                        end else begin
                            r_i  <= r_i + 1'b1;
                            r_st <= S_AR;
                        end
                    end else begin
                        r_c  <= r_c + 1'b1;
                        r_st <= S_AR;
                    end
                end
                S_RC: begin
                    if (cnt_rd == '0) begin
                        r_empty <= 1'b1;
                        r_pp    <= (r_rp >= np) ? '0 : r_rp;
                        r_d     <= '0;
                        r_st    <= S_RR;
                    end else begin
                        r_st <= S_RN;
                    end
                end
                S_RR: begin
                    r_st <= S_RW;
                end
                S_RW: begin
                    if (last_d) begin
                        r_rp <= r_pp + 1'b1;
                        r_st <= S_RN;
                    end else begin
                        r_d  <= r_d + 1'b1;
                        r_st <= S_RR;
                    end
                end
                S_RN: begin
                    r_d <= '0;
                    if (last_c) begin
                        if (r_empty) begin
                            r_oupd   <= 1'b0;
                            r_ovalid <= 1'b1;
                            r_st     <= S_RESP;
                        end else begin
                            r_c    <= '0;
                            r_base <= '0;
                            r_init <= 1'b0;
                            r_st   <= S_SS;
                        end
                    end else begin
                        r_c  <= r_c + 1'b1;
                        r_st <= S_RC;
                    end
                end
                S_SS: begin
                    r_sum <= '0;
                    r_i   <= r_init ? r_base : '0;
                    r_lim <= r_init ? r_base + r_size : np;
                    r_st  <= (r_init && r_size == '0) ? S_DV : S_SR;
                end
                S_SR: begin
                    r_st <= S_SA;
                end
                S_SA: begin
                    if (r_init || r_ard == r_c) begin
                        r_sum <= r_sum + km_pkg::SUM_W'(r_prd);
                    end
                    if (r_i + 1'b1 == r_lim) begin
                        r_st <= S_DV;
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= S_SR;
                    end
                end
                S_DV: begin
                    r_st <= (r_init && r_size == '0) ? S_NX : S_DW;
                end
                S_DW: begin
                    if (div_done) begin
                        r_st <= S_NX;
                    end
                end
                S_NX: begin
                    if (last_d) begin
                        r_d <= '0;
                        if (last_c) begin
                            r_oupd   <= !r_init;
                            r_ovalid <= 1'b1;
                            r_st     <= S_RESP;
                        end else begin
                            r_c    <= r_c + 1'b1;
                            r_base <= r_base + r_size;
                            r_st   <= S_SS;
                        end
                    end else begin
                        r_d  <= r_d + 1'b1;
                        r_st <= S_SS;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_read_value = r_orv;
    assign o_updated    = r_oupd;
    assign o_status     = r_ost;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken while a result is pending");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_read_value)
                                   && $stable(o_updated) && $stable(o_status)))
        else $error("stalled result changed");

    a_pass_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && i_kind == km_pkg::KIND_PASS) |=> (r_st == S_AR && !r_empty))
        else $error("pass did not start with a clean assignment phase");

    a_updated_only_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_updated) |-> (!o_status && o_read_value == '0))
        else $error("update flag on a non-pass result");

endmodule

// ===== sv/km_sqd.sv =====
// ----------------------------------------------------------------------------
// km_sqd
// Squared-difference unit with a saturating 64-bit distance accumulator.
// ----------------------------------------------------------------------------
module km_sqd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  km_pkg::t_sqd_ctl              i_ctl,
    input  logic signed [km_pkg::COORD_W-1:0] i_a,
    input  logic signed [km_pkg::COORD_W-1:0] i_b,
    output logic [km_pkg::DIST_W-1:0]     o_acc
);

    logic signed [km_pkg::COORD_W:0]   diff;
    logic [km_pkg::COORD_W-1:0]        mag;
    logic [km_pkg::DIST_W-1:0]         r_prod;
    logic [km_pkg::DIST_W-1:0]         r_acc;
    logic [km_pkg::DIST_W-1:0]         base;
    logic [km_pkg::DIST_W:0]           sum;

    assign diff = {i_a[km_pkg::COORD_W-1], i_a} - {i_b[km_pkg::COORD_W-1], i_b};
    assign mag  = diff[km_pkg::COORD_W] ? km_pkg::COORD_W'(-diff)
                                        : diff[km_pkg::COORD_W-1:0];
    assign base = i_ctl.first ? '0 : r_acc;
    assign sum  = {1'b0, base} + {1'b0, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= km_pkg::DIST_W'(mag) * km_pkg::DIST_W'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= sum[km_pkg::DIST_W] ? '1 : sum[km_pkg::DIST_W-1:0];
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== sv/km_div.sv =====
// ----------------------------------------------------------------------------
// km_div
// Radix-2 restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module km_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [km_pkg::SUM_W-1:0] i_dividend,
    input  logic [km_pkg::NP_W-1:0]         i_divisor,
    output logic                            o_done,
    output logic signed [km_pkg::SUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(km_pkg::SUM_W + 1);

    logic [km_pkg::SUM_W-1:0] r_q;
    logic [km_pkg::NP_W-1:0]  r_r;
    logic [km_pkg::NP_W-1:0]  r_dv;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [km_pkg::NP_W:0]    trial;
    logic                     fits;

    assign trial = {r_r, r_q[km_pkg::SUM_W-1]};
    assign fits  = trial >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(km_pkg::SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[km_pkg::SUM_W-1];
            r_q   <= i_dividend[km_pkg::SUM_W-1] ? km_pkg::SUM_W'(-i_dividend)
                                                 : i_dividend;
            r_r   <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            r_r <= fits ? km_pkg::NP_W'(trial - {1'b0, r_dv}) : trial[km_pkg::NP_W-1:0];
            r_q <= {r_q[km_pkg::SUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? km_pkg::SUM_W'(-r_q) : r_q;

endmodule
